>>> rtl/core/gb3_pkg.sv
// gb3_pkg: shared types and constants of the 3x3 rgba blur core
// no dependencies; imported by every module of the core except gb3_ram

package gb3_pkg;

  localparam int unsigned PIX_W     = 32;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned ROW_CFG_W = 48;
  localparam int unsigned WIDTH_W   = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TAPS      = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd4;

  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_ONE   = 2'd1;
  localparam logic [1:0] RS_MANY  = 2'd2;
  localparam logic [1:0] RS_FLUSH = 2'd3;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef logic [TAPS-1:0][PIX_W-1:0] gb3_win_t;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } gb3_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       row_end;
    logic       frame_end;
  } gb3_out_t;

  typedef struct packed {
    gb3_win_t win;
    logic     row_end;
    logic     frame_end;
  } gb3_job_t;

endpackage

>>> rtl/core/gaussian_blur_3x3_rgba_core.sv
// gaussian_blur_3x3_rgba_core: top level of the 3x3 rgba blur, config registers
// depends on gb3_pkg, gb3_front, gb3_jobq, gb3_back
//
// usage
//   in_*  : valid/ready beat of gb3_in_t; action selects pixel or flush tick.
//           pixels arrive in raster order, flush ticks follow the last row.
//   out_* : valid/ready beat of gb3_out_t, one per output pixel, with
//           row_end and frame_end marks.
//   cfg_* : write enable, register index and data; write only while idle.
// flow
//   a pixel of the first row is written to both line rams as it is accepted;
//   a later pixel reads both line rams, then makes one queue push per result;
//   a flush tick makes three reads of each line ram and then the push.
//   each result passes the back as 9 multiply-accumulate steps in four
//   channel lanes, one gain step and the output state; the back takes a new
//   job only after its result has left the output.
//   a two-entry job queue lets the front keep accepting while a result
//   waits at the output; when out_ready is low the back holds its result,
//   the queue fills and in_ready drops.
// reset
//   rst_n clears control state and the config registers (width 1, zero
//   weights, gain 1.0); line ram contents are undefined until written.

module gaussian_blur_3x3_rgba_core
  import gb3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gb3_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gb3_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_CFG_W-1:0] cfg_wdata
);

  logic [WIDTH_W-1:0]   width_r;
  logic [ROW_CFG_W-1:0] coef_top_r, coef_mid_r, coef_bot_r;
  logic [COEF_W-1:0]    gain_r;

  logic     fq_valid, fq_ready, bq_valid, bq_ready;
  gb3_job_t fq_job, bq_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_W'(1);
      coef_top_r <= '0;
      coef_mid_r <= '0;
      coef_bot_r <= '0;
      gain_r     <= COEF_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: width_r    <= cfg_wdata[WIDTH_W-1:0];
        REG_COEF_TOP:    coef_top_r <= cfg_wdata;
        REG_COEF_MIDDLE: coef_mid_r <= cfg_wdata;
        REG_COEF_BOTTOM: coef_bot_r <= cfg_wdata;
        REG_GAIN:        gain_r     <= cfg_wdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_width(width_r),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_job    (fq_job)
  );

  gb3_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_job  (fq_job),
    .pop_valid (bq_valid),
    .pop_ready (bq_ready),
    .pop_job   (bq_job)
  );

  gb3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (bq_valid),
    .q_ready  (bq_ready),
    .q_job    (bq_job),
    .coef_top (coef_top_r),
    .coef_mid (coef_mid_r),
    .coef_bot (coef_bot_r),
    .gain     (gain_r),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/gb3_ram.sv
// gb3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module gb3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/gb3_front.sv
// gb3_front: accepts pixels and flush beats, keeps the line stores and window,
// and issues one job per output pixel; uses gb3_pkg and gb3_ram

module gb3_front
  import gb3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gb3_in_t            in_data,
  input  logic [WIDTH_W-1:0] cfg_width,
  output logic               q_valid,
  input  logic               q_ready,
  output gb3_job_t           q_job
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned EW = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ?
                               $clog2(MAX_WIDTH + 1) : WIDTH_W;

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_PXRD = 7'b0000010,
    F_EM0  = 7'b0000100,
    F_EM1  = 7'b0001000,
    F_FL0  = 7'b0010000,
    F_FL1  = 7'b0100000,
    F_FL2  = 7'b1000000
  } gb3_fstate_t;

  gb3_fstate_t      state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       rows_r, rows_nxt;
  gb3_win_t         win_r, win_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic [CW-1:0]    c_r, c_nxt;
  logic [CW-1:0]    kr_r, kr_nxt;
  logic             last_r, last_nxt;
  logic             re_r, re_nxt;
  logic             fe_r, fe_nxt;

  logic [EW-1:0]    w_ext, eff_w, c_inc;
  logic [CW-1:0]    c_sel, kl, kr;
  logic             last;
  logic [PIX_W-1:0] in_pix;
  logic             accept;

  logic             ram_we;
  logic [CW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] up_wdata, mid_wdata, up_rdata, mid_rdata;
  gb3_win_t         w1;

  function automatic gb3_win_t shift_in(gb3_win_t w, logic [PIX_W-1:0] a,
                                        logic [PIX_W-1:0] b, logic [PIX_W-1:0] d);
    gb3_win_t o;
    o    = w;
    o[0] = w[1]; o[1] = w[2]; o[2] = a;
    o[3] = w[4]; o[4] = w[5]; o[5] = b;
    o[6] = w[7]; o[7] = w[8]; o[8] = d;
    return o;
  endfunction

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(up_wdata),
    .raddr(ram_raddr),
    .rdata(up_rdata)
  );

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(mid_wdata),
    .raddr(ram_raddr),
    .rdata(mid_rdata)
  );

  assign in_pix = {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};
  assign in_ready = (state_r == F_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    w_ext = EW'(cfg_width);
    if (w_ext == '0) begin
      eff_w = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = w_ext;
    end
    if (in_data.action == ACT_FLUSH && rows_r != RS_FLUSH) begin
      c_sel = '0;
    end else begin
      c_sel = cnt_r;
    end
    c_inc = EW'(c_sel) + EW'(1);
    last  = (c_inc >= eff_w);
    kl    = (c_sel == '0) ? '0 : c_sel - CW'(1);
    kr    = last ? c_sel : c_sel + CW'(1);
  end

  always_comb begin
    w1 = shift_in(win_r, up_rdata, mid_rdata, pix_r);
    if (c_r == '0) begin
      w1[0] = w1[2]; w1[1] = w1[2];
      w1[3] = w1[5]; w1[4] = w1[5];
      w1[6] = w1[8]; w1[7] = w1[8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rows_nxt  = rows_r;
    win_nxt   = win_r;
    pix_nxt   = pix_r;
    c_nxt     = c_r;
    kr_nxt    = kr_r;
    last_nxt  = last_r;
    re_nxt    = re_r;
    fe_nxt    = fe_r;
    ram_we    = 1'b0;
    ram_waddr = c_r;
    up_wdata  = mid_rdata;
    mid_wdata = pix_r;
    ram_raddr = c_r;
    q_valid   = 1'b0;
    q_job.win       = win_r;
    q_job.row_end   = re_r;
    q_job.frame_end = fe_r;

    unique case (state_r)
      F_IDLE: begin
        ram_raddr = (in_data.action == ACT_FLUSH) ? kl : cnt_r;
        if (accept) begin
          pix_nxt  = in_pix;
          c_nxt    = c_sel;
          kr_nxt   = kr;
          last_nxt = last;
          if (in_data.action == ACT_PIXEL) begin
            re_nxt = 1'b1;
            fe_nxt = 1'b0;
            if (rows_r != RS_FLUSH) begin
              if (rows_r == RS_NONE) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r;
                up_wdata  = in_pix;
                mid_wdata = in_pix;
              end else begin
                state_nxt = F_PXRD;
              end
              if (last) begin
                cnt_nxt = '0;
                if (rows_r == RS_NONE) begin
                  rows_nxt = RS_ONE;
                end else begin
                  rows_nxt = RS_MANY;
                end
              end else begin
                cnt_nxt = cnt_r + CW'(1);
              end
            end
          end else if (rows_r != RS_NONE && (rows_r == RS_FLUSH || cnt_r == '0)) begin
            re_nxt    = last;
            fe_nxt    = last;
            state_nxt = F_FL0;
            if (last) begin
              cnt_nxt  = '0;
              rows_nxt = RS_NONE;
            end else begin
              cnt_nxt  = c_sel + CW'(1);
              rows_nxt = RS_FLUSH;
            end
          end
        end
      end
      F_PXRD: begin
        ram_we = 1'b1;
        if (c_r != '0) begin
          win_nxt   = w1;
          state_nxt = F_EM0;
        end else if (last_r) begin
          win_nxt   = shift_in(w1, w1[2], w1[5], w1[8]);
          state_nxt = F_EM1;
        end else begin
          win_nxt   = w1;
          state_nxt = F_IDLE;
        end
      end
      F_EM0: begin
        q_valid         = 1'b1;
        q_job.row_end   = 1'b0;
        q_job.frame_end = 1'b0;
        if (q_ready) begin
          if (last_r) begin
            win_nxt   = shift_in(win_r, win_r[2], win_r[5], win_r[8]);
            state_nxt = F_EM1;
          end else begin
            state_nxt = F_IDLE;
          end
        end
      end
      F_EM1: begin
        q_valid = 1'b1;
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      F_FL0: begin
        ram_raddr  = c_r;
        win_nxt[0] = up_rdata;
        win_nxt[3] = mid_rdata;
        win_nxt[6] = mid_rdata;
        state_nxt  = F_FL1;
      end
      F_FL1: begin
        ram_raddr  = kr_r;
        win_nxt[1] = up_rdata;
        win_nxt[4] = mid_rdata;
        win_nxt[7] = mid_rdata;
        state_nxt  = F_FL2;
      end
      F_FL2: begin
        win_nxt[2] = up_rdata;
        win_nxt[5] = mid_rdata;
        win_nxt[8] = mid_rdata;
        state_nxt  = F_EM1;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
      rows_r  <= RS_NONE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rows_r  <= rows_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    pix_r  <= pix_nxt;
    c_r    <= c_nxt;
    kr_r   <= kr_nxt;
    last_r <= last_nxt;
    re_r   <= re_nxt;
    fe_r   <= fe_nxt;
  end

endmodule

>>> rtl/core/gb3_jobq.sv
// gb3_jobq: two-entry job queue between front and back
// uses gb3_pkg for the job type

module gb3_jobq
  import gb3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  gb3_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output gb3_job_t pop_job
);

  gb3_job_t   slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_job    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (do_push) begin
        wptr_r <= ~wptr_r;
      end
      if (do_pop) begin
        rptr_r <= ~rptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/core/gb3_back.sv
// gb3_back: weighted sum over the 3x3 window in four channel lanes, gain and
// saturation, output register; uses gb3_pkg

module gb3_back
  import gb3_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  gb3_job_t             q_job,
  input  logic [ROW_CFG_W-1:0] coef_top,
  input  logic [ROW_CFG_W-1:0] coef_mid,
  input  logic [ROW_CFG_W-1:0] coef_bot,
  input  logic [COEF_W-1:0]    gain,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gb3_out_t             out_data
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MAC  = 4'b0010,
    B_GAIN = 4'b0100,
    B_OUT  = 4'b1000
  } gb3_bstate_t;

  gb3_bstate_t               state_r;
  gb3_job_t                  job_r;
  logic [3:0]                k_r;
  logic [3:0][27:0]          acc_r;
  logic [3:0][27:0]          acc_nxt;
  logic [3:0][7:0]           sat;
  logic [TAPS-1:0][COEF_W-1:0] wgt;
  logic [COEF_W-1:0]         wsel;
  logic [PIX_W-1:0]          psel;
  logic [43:0]               gprod;
  gb3_out_t                  out_r;

  assign wgt[0] = coef_top[15:0];
  assign wgt[1] = coef_top[31:16];
  assign wgt[2] = coef_top[47:32];
  assign wgt[3] = coef_mid[15:0];
  assign wgt[4] = coef_mid[31:16];
  assign wgt[5] = coef_mid[47:32];
  assign wgt[6] = coef_bot[15:0];
  assign wgt[7] = coef_bot[31:16];
  assign wgt[8] = coef_bot[47:32];

  assign wsel = wgt[k_r];
  assign psel = job_r.win[k_r];

  always_comb begin
    gprod = '0;
    for (int ch = 0; ch < 4; ch++) begin
      acc_nxt[ch] = acc_r[ch] + 28'(wsel * psel[8*ch +: 8]);
      gprod       = acc_r[ch] * gain;
      sat[ch]     = (gprod[43:16] > 28'd255) ? 8'hff : gprod[23:16];
    end
  end

  assign q_ready   = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            k_r     <= '0;
            state_r <= B_MAC;
          end
        end
        B_MAC: begin
          if (k_r == 4'(TAPS - 1)) begin
            state_r <= B_GAIN;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        B_GAIN: begin
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) begin
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && q_valid) begin
      job_r <= q_job;
      acc_r <= '0;
    end else if (state_r == B_MAC) begin
      acc_r <= acc_nxt;
    end
    if (state_r == B_GAIN) begin
      out_r.out_red   <= sat[0];
      out_r.out_green <= sat[1];
      out_r.out_blue  <= sat[2];
      out_r.out_alpha <= sat[3];
      out_r.row_end   <= job_r.row_end;
      out_r.frame_end <= job_r.frame_end;
    end
  end

endmodule

>>> bench/gb3_blur_checker.sv
// gb3_blur_checker: watches the pixel, result and register ports of the blur core,
// predicts every output pixel and compares it with what the core delivers
// depends on gb3_pkg
module gb3_blur_checker
  import gb3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  gb3_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  gb3_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ROW_CFG_W-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WIDTH_W-1:0]   width_reg;
  logic [ROW_CFG_W-1:0] coef_row [3];
  logic [COEF_W-1:0]    gain_reg;
  logic [PIX_W-1:0]     upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0]     middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0]     win [TAPS];
  int unsigned          col_cnt;
  logic [1:0]           row_state;
  gb3_out_t             blur_q [$];

  assign pending = blur_q.size();

  function automatic gb3_out_t blur_pixel(logic re, logic fe);
    gb3_out_t r;
    longint unsigned acc;
    longint unsigned v;
    logic [7:0] res [4];
    for (int ch = 0; ch < 4; ch++) begin
      acc = 0;
      for (int k = 0; k < 9; k++) begin
        acc += longint'(coef_row[k/3][16*(k%3) +: 16]) * longint'(win[k][8*ch +: 8]);
      end
      v = (acc * longint'(gain_reg)) >> 16;
      res[ch] = (v > 255) ? 8'd255 : v[7:0];
    end
    r.out_red = res[0];
    r.out_green = res[1];
    r.out_blue = res[2];
    r.out_alpha = res[3];
    r.row_end = re;
    r.frame_end = fe;
    return r;
  endfunction

  function automatic void shift_win(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                    logic [PIX_W-1:0] d);
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = a;
    win[5] = b;
    win[8] = d;
  endfunction

  task automatic predict(gb3_in_t b);
    int unsigned w;
    int unsigned c;
    int unsigned kl;
    int unsigned kr;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic last;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    c = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
    if (b.action == ACT_PIXEL) begin
      pix = {b.in_alpha, b.in_blue, b.in_green, b.in_red};
      last = (c + 1 >= w);
      if (row_state == RS_FLUSH) return;
      if (row_state == RS_NONE) begin
        upper_mem[c] = pix;
        middle_mem[c] = pix;
      end else begin
        up = upper_mem[c];
        mid = middle_mem[c];
        shift_win(up, mid, pix);
        if (c == 0) begin
          for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3+2];
            win[r*3+1] = win[r*3+2];
          end
        end
        upper_mem[c] = mid;
        middle_mem[c] = pix;
        if (c >= 1) blur_q.push_back(blur_pixel(1'b0, 1'b0));
        if (last) begin
          shift_win(win[2], win[5], win[8]);
          blur_q.push_back(blur_pixel(1'b1, 1'b0));
        end
      end
      if (last) begin
        col_cnt = 0;
        if (row_state != RS_MANY) row_state = row_state + 2'd1;
      end else begin
        col_cnt = c + 1;
      end
      return;
    end
    if (row_state == RS_NONE) return;
    if (row_state != RS_FLUSH) begin
      if (col_cnt != 0) return;
      row_state = RS_FLUSH;
      c = 0;
    end
    kl = (c == 0) ? 0 : c - 1;
    kr = (c + 1 < w) ? c + 1 : c;
    if (kr >= MAX_WIDTH) kr = c;
    last = (c + 1 >= w);
    win[0] = upper_mem[kl];
    win[1] = upper_mem[c];
    win[2] = upper_mem[kr];
    win[3] = middle_mem[kl];
    win[4] = middle_mem[c];
    win[5] = middle_mem[kr];
    win[6] = middle_mem[kl];
    win[7] = middle_mem[c];
    win[8] = middle_mem[kr];
    blur_q.push_back(blur_pixel(last, last));
    if (last) begin
      col_cnt = 0;
      row_state = RS_NONE;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic note_fail(string what, gb3_out_t exp_px, gb3_out_t act_px);
    if (fail_count < 10) begin
      $display("%s: expected %h actual %h", what, exp_px, act_px);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    gb3_out_t exp_px;
    if (!rst_n) begin
      width_reg <= WIDTH_W'(1);
      gain_reg <= COEF_W'(256);
      for (int i = 0; i < 3; i++) coef_row[i] <= '0;
      for (int i = 0; i < TAPS; i++) win[i] = '0;
      col_cnt = 0;
      row_state = RS_NONE;
      blur_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: width_reg <= cfg_wdata[WIDTH_W-1:0];
          REG_COEF_TOP:    coef_row[0] <= cfg_wdata;
          REG_COEF_MIDDLE: coef_row[1] <= cfg_wdata;
          REG_COEF_BOTTOM: coef_row[2] <= cfg_wdata;
          REG_GAIN:        gain_reg <= cfg_wdata[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict(in_data);
      if (out_valid && out_ready) begin
        if (blur_q.size() == 0) begin
          note_fail("unexpected beat", '0, out_data);
        end else begin
          exp_px = blur_q.pop_front();
          if (exp_px.out_red !== out_data.out_red || exp_px.out_green !== out_data.out_green ||
              exp_px.out_blue !== out_data.out_blue ||
              exp_px.out_alpha !== out_data.out_alpha ||
              exp_px.row_end !== out_data.row_end || exp_px.frame_end !== out_data.frame_end)
          begin
            note_fail("pixel mismatch", exp_px, out_data);
          end
        end
      end
    end
  end

endmodule

>>> bench/tb_gaussian_blur_3x3_rgba_core.sv
// tb_gaussian_blur_3x3_rgba_core: drives frames, flush ticks and register writes into
// the blur core with random bursts and output stalls; verdict from gb3_blur_checker
// depends on gb3_pkg, gaussian_blur_3x3_rgba_core, gb3_blur_checker
module tb_gaussian_blur_3x3_rgba_core;
  import gb3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  gb3_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  gb3_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_CFG_W-1:0] cfg_wdata;
  int                   fail_count;
  int                   pending;
  int unsigned          cycle_cnt;
  int                   burst_left;
  int                   beats_sent;
  bit                   hold_req;

  gaussian_blur_3x3_rgba_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  gb3_blur_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_gaussian_blur_3x3_rgba_core failed");
      $finish;
    end
  end

  // receiver stall pattern, plus one long hold-off
  initial begin
    int mode;
    int span;
    bit hold_used;
    out_ready = 1'b0;
    hold_used = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      if (hold_req && !hold_used) begin
        hold_used = 1;
        repeat (600) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_beat(logic act, logic [31:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_data <= {act, pix[7:0], pix[15:8], pix[23:16], pix[31:24]};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 8'h00, 8'hff, 8'($urandom_range(0, 255))};
      default: return $urandom;
    endcase
  endfunction

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_kernel(logic [15:0] k [9], logic [15:0] g);
    write_reg(REG_COEF_TOP, {k[2], k[1], k[0]});
    write_reg(REG_COEF_MIDDLE, {k[5], k[4], k[3]});
    write_reg(REG_COEF_BOTTOM, {k[8], k[7], k[6]});
    write_reg(REG_GAIN, {32'h0, g});
  endtask

  // one frame; noisy frames add ignored flushes and pixels
  task automatic run_frame(int w, int rows, bit noisy);
    int eff;
    int unsigned pos;
    eff = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
    if (noisy && $urandom_range(0, 1)) send_beat(ACT_FLUSH, $urandom);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < eff; c++) begin
        if (noisy && c > 0 && $urandom_range(0, 15) == 0) send_beat(ACT_FLUSH, $urandom);
        send_beat(ACT_PIXEL, rand_pixel());
        beats_sent++;
      end
    end
    pos = $urandom_range(1, eff);
    for (int c = 0; c < eff; c++) begin
      if (noisy && c > 0 && c == pos) send_beat(ACT_PIXEL, $urandom);
      send_beat(ACT_FLUSH, $urandom);
      beats_sent++;
    end
  endtask

  initial begin
    logic [15:0] kern [9];
    int w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    cycle_cnt = 0;
    burst_left = 0;
    beats_sent = 0;
    hold_req = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    kern = '{16, 32, 16, 32, 64, 32, 16, 32, 16};
    set_kernel(kern, 16'd256);
    write_reg(REG_IMAGE_WIDTH, 48'd3);
    send_beat(ACT_FLUSH, 32'hffff_ffff);
    send_beat(ACT_PIXEL, 32'h0000_0000);
    send_beat(ACT_PIXEL, 32'hffff_ffff);
    send_beat(ACT_PIXEL, 32'h00ff_00ff);
    send_beat(ACT_PIXEL, 32'hff00_ff00);
    send_beat(ACT_FLUSH, 32'h0);
    send_beat(ACT_PIXEL, 32'h8040_2010);
    send_beat(ACT_PIXEL, 32'h0102_0408);
    send_beat(ACT_FLUSH, 32'h0);
    send_beat(ACT_PIXEL, 32'hdead_beef);
    send_beat(ACT_FLUSH, 32'h0);
    send_beat(ACT_FLUSH, 32'h0);
    settle();
    write_reg(REG_IMAGE_WIDTH, 48'd1);
    kern = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
             16'hffff, 16'hffff, 16'hffff, 16'hffff};
    set_kernel(kern, 16'hffff);
    send_beat(ACT_PIXEL, 32'h0000_00ff);
    send_beat(ACT_FLUSH, 32'h0);
    settle();
    write_reg(REG_IMAGE_WIDTH, 48'd0);
    kern = '{0, 0, 0, 0, 16'hffff, 0, 0, 0, 0};
    set_kernel(kern, 16'd0);
    send_beat(ACT_PIXEL, 32'h7f7f_7f7f);
    send_beat(ACT_PIXEL, 32'hffff_ffff);
    send_beat(ACT_FLUSH, 32'h0);
    settle();

    hold_req = 1;
    write_reg(REG_IMAGE_WIDTH, 48'd8);
    kern = '{16, 32, 16, 32, 64, 32, 16, 32, 16};
    set_kernel(kern, 16'd256);
    run_frame(8, 4, 0);
    settle();

    write_reg(REG_IMAGE_WIDTH, 48'd300);
    run_frame(300, 1, 0);
    settle();

    while (beats_sent < 1850) begin
      if ($urandom_range(0, 2) == 0) begin
        for (int i = 0; i < 9; i++) begin
          kern[i] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
        end
        set_kernel(kern, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                                                      16'($urandom_range(32, 512)));
      end
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      write_reg(REG_IMAGE_WIDTH, ROW_CFG_W'(w));
      run_frame(w, $urandom_range(1, 5), $urandom_range(0, 3) == 0);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_gaussian_blur_3x3_rgba_core passed");
    end else begin
      $display("tb_gaussian_blur_3x3_rgba_core failed");
    end
    $finish;
  end

endmodule
